[rtl/core/fat_volume_geometry_macros.svh]
// Assertion macros for the FAT volume geometry block.
// Used by the top level only; needs clock and reset in scope.
`ifndef FAT_VOLUME_GEOMETRY_MACROS_SVH
`define FAT_VOLUME_GEOMETRY_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FVG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FVG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fvg_pkg.sv]
// Shared types and constants for the FAT volume geometry block.
// No dependencies.
`timescale 1ns / 1ps
package fvg_pkg;

   localparam int unsigned LIMIT_FAT12 = 4085;
   localparam int unsigned LIMIT_FAT16 = 65525;
   localparam int unsigned DIR_ENTRY_SHIFT = 5;

   localparam int unsigned SPAN_NUM_W = 22;
   localparam int unsigned SPAN_DEN_W = 16;
   localparam int unsigned SPAN_W = 21;
   localparam int unsigned CLUS_NUM_W = 32;
   localparam int unsigned CLUS_DEN_W = 8;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_SIZE,
      STATUS_FAT12
   } status_type;

   typedef struct packed {
      logic        bad_size;
      logic [31:0] total;
      logic [31:0] tbl;
      logic [31:0] prod;
      logic [31:0] fat_lba;
      logic [15:0] rsv;
      logic [7:0]  spc;
      logic [31:0] root_clus;
   } front_type;

   typedef struct packed {
      logic              bad_size;
      logic [31:0]       total;
      logic [31:0]       tbl;
      logic [SPAN_W-1:0] span;
      logic [31:0]       fat_lba;
      logic [31:0]       root_lba;
      logic [31:0]       data_start;
      logic [31:0]       root_clus;
   } mid_type;

endpackage

[rtl/core/fvg_front.sv]
// Input stage: picks the sector counts, forms the root span numerator and the FAT product.
// Depends on fvg_pkg.
`timescale 1ns / 1ps
module fvg_front
   import fvg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [31:0]           partition_start,
   input  logic [15:0]           sector_bytes,
   input  logic [7:0]            cluster_sectors,
   input  logic [15:0]           reserved_count,
   input  logic [7:0]            table_copies,
   input  logic [15:0]           root_entry_count,
   input  logic [15:0]           short_total,
   input  logic [31:0]           long_total,
   input  logic [15:0]           short_table_size,
   input  logic [31:0]           long_table_size,
   input  logic [31:0]           boot_root_cluster,
   output logic                  out_valid,
   output logic [SPAN_NUM_W-1:0] out_num,
   output logic [SPAN_DEN_W-1:0] out_den,
   output front_type             out_side
);

   logic                  valid_ff;
   logic [SPAN_NUM_W-1:0] num_ff, num_in;
   logic [SPAN_DEN_W-1:0] den_ff;
   front_type             side_ff, side_in;

   always_comb begin
      side_in.bad_size  = (sector_bytes == '0) || (cluster_sectors == '0);
      side_in.total     = (short_total != '0) ? 32'(short_total) : long_total;
      side_in.tbl       = (short_table_size != '0) ? 32'(short_table_size) : long_table_size;
      side_in.prod      = 32'(40'(table_copies) * 40'(side_in.tbl));
      side_in.fat_lba   = partition_start + 32'(reserved_count);
      side_in.rsv       = reserved_count;
      side_in.spc       = cluster_sectors;
      side_in.root_clus = boot_root_cluster;
      num_in = (SPAN_NUM_W'(root_entry_count) << DIR_ENTRY_SHIFT)
         + SPAN_NUM_W'(sector_bytes) - SPAN_NUM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         den_ff  <= sector_bytes;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

[rtl/core/fvg_div_pipe.sv]
// Restoring divider with one quotient bit per register stage and a carried sideband.
// Depends on fvg_pkg for default widths.
`timescale 1ns / 1ps
module fvg_div_pipe
   import fvg_pkg::*;
#(
   parameter int unsigned NUM_W  = CLUS_NUM_W,
   parameter int unsigned DEN_W  = CLUS_DEN_W,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              stage_valid [NUM_W+1];
   logic [NUM_W-1:0]  stage_num   [NUM_W+1];
   logic [DEN_W-1:0]  stage_rem   [NUM_W+1];
   logic [DEN_W-1:0]  stage_den   [NUM_W+1];
   logic [SIDE_W-1:0] stage_side  [NUM_W+1];

   assign stage_valid[0] = in_valid;
   assign stage_num[0]   = in_num;
   assign stage_rem[0]   = '0;
   assign stage_den[0]   = in_den;
   assign stage_side[0]  = in_side;

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              valid_ff;
      logic [NUM_W-1:0]  num_ff, num_in;
      logic [DEN_W-1:0]  rem_ff, rem_in;
      logic [DEN_W-1:0]  den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              fits;

      always_comb begin
         trial  = {stage_rem[s], stage_num[s][NUM_W-1]};
         diff   = trial - {1'b0, stage_den[s]};
         fits   = trial >= {1'b0, stage_den[s]};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {stage_num[s][NUM_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= stage_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff  <= num_in;
            rem_ff  <= rem_in;
            den_ff  <= stage_den[s];
            side_ff <= stage_side[s];
         end
      end

      assign stage_valid[s+1] = valid_ff;
      assign stage_num[s+1]   = num_ff;
      assign stage_rem[s+1]   = rem_ff;
      assign stage_den[s+1]   = den_ff;
      assign stage_side[s+1]  = side_ff;
   end

   assign out_valid = stage_valid[NUM_W];
   assign out_quo   = stage_num[NUM_W];
   assign out_side  = stage_side[NUM_W];

endmodule

[rtl/core/fvg_mid.sv]
// Middle stage: region start sectors and the data sector count from the root span.
// Depends on fvg_pkg.
`timescale 1ns / 1ps
module fvg_mid
   import fvg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [SPAN_NUM_W-1:0] in_quo,
   input  front_type             in_side,
   output logic                  out_valid,
   output logic [CLUS_NUM_W-1:0] out_num,
   output logic [CLUS_DEN_W-1:0] out_den,
   output mid_type               out_side
);

   logic                  valid_ff;
   logic [CLUS_NUM_W-1:0] data_ff, data_in;
   logic [CLUS_DEN_W-1:0] den_ff;
   mid_type               side_ff, side_in;
   logic [31:0]           span32;

   always_comb begin
      span32             = 32'(in_quo);
      side_in.bad_size   = in_side.bad_size;
      side_in.total      = in_side.total;
      side_in.tbl        = in_side.tbl;
      side_in.span       = in_quo[SPAN_W-1:0];
      side_in.fat_lba    = in_side.fat_lba;
      side_in.root_lba   = in_side.fat_lba + in_side.prod;
      side_in.data_start = in_side.fat_lba + in_side.prod + span32;
      side_in.root_clus  = in_side.root_clus;
      data_in = in_side.total - (32'(in_side.rsv) + in_side.prod + span32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         den_ff  <= in_side.spc;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = data_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

[rtl/core/fvg_back.sv]
// Output stage: classifies the volume, applies the error cases and holds the response.
// Depends on fvg_pkg.
`timescale 1ns / 1ps
module fvg_back
   import fvg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [CLUS_NUM_W-1:0] in_quo,
   input  mid_type               in_side,
   output logic                  out_valid,
   output logic [1:0]            status,
   output logic                  is_fat32,
   output logic [31:0]           volume_sectors,
   output logic [31:0]           table_sectors,
   output logic [SPAN_W-1:0]     root_dir_span,
   output logic [31:0]           first_fat_lba,
   output logic [31:0]           root_region_lba,
   output logic [31:0]           data_area_lba,
   output logic [31:0]           root_start_cluster,
   output logic [31:0]           cluster_total
);

   logic              valid_ff;
   status_type        status_ff, status_in;
   logic              big_ff, big_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       tbl_ff, tbl_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [31:0]       fat_ff, fat_in;
   logic [31:0]       root_ff, root_in;
   logic [31:0]       data_ff, data_in;
   logic [31:0]       clus_ff, clus_in;
   logic [31:0]       count_ff, count_in;
   logic              keep;

   always_comb begin
      if (in_side.bad_size) begin
         status_in = STATUS_BAD_SIZE;
      end else if (in_quo < 32'(LIMIT_FAT12)) begin
         status_in = STATUS_FAT12;
      end else begin
         status_in = STATUS_OK;
      end
      keep     = (status_in == STATUS_OK);
      big_in   = keep && (in_quo >= 32'(LIMIT_FAT16));
      total_in = keep ? in_side.total : '0;
      tbl_in   = keep ? in_side.tbl : '0;
      span_in  = keep ? in_side.span : '0;
      fat_in   = keep ? in_side.fat_lba : '0;
      root_in  = keep ? in_side.root_lba : '0;
      data_in  = keep ? in_side.data_start : '0;
      clus_in  = big_in ? in_side.root_clus : '0;
      count_in = keep ? in_quo : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         big_ff    <= big_in;
         total_ff  <= total_in;
         tbl_ff    <= tbl_in;
         span_ff   <= span_in;
         fat_ff    <= fat_in;
         root_ff   <= root_in;
         data_ff   <= data_in;
         clus_ff   <= clus_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid          = valid_ff;
   assign status             = status_ff;
   assign is_fat32           = big_ff;
   assign volume_sectors     = total_ff;
   assign table_sectors      = tbl_ff;
   assign root_dir_span      = span_ff;
   assign first_fat_lba      = fat_ff;
   assign root_region_lba    = root_ff;
   assign data_area_lba      = data_ff;
   assign root_start_cluster = clus_ff;
   assign cluster_total      = count_ff;

endmodule

[rtl/core/fat_volume_geometry.sv]
// FAT volume geometry: one request per boot record gives one response with the
// volume type, region start sectors and cluster count. The block accepts a request
// every cycle unless a response is stalled; each request passes through one input
// stage, a 22-stage divider for the root directory span, one stage for the data sector
// count, a 32-stage divider for the cluster count and one output stage. A stalled
// response holds the whole pipeline in place. Depends on fvg_pkg and the fvg_ modules.
`timescale 1ns / 1ps
`include "fat_volume_geometry_macros.svh"
module fat_volume_geometry
   import fvg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_partition_start,
   input  logic [15:0]       req_sector_bytes,
   input  logic [7:0]        req_cluster_sectors,
   input  logic [15:0]       req_reserved_count,
   input  logic [7:0]        req_table_copies,
   input  logic [15:0]       req_root_entry_count,
   input  logic [15:0]       req_short_total,
   input  logic [31:0]       req_long_total,
   input  logic [15:0]       req_short_table_size,
   input  logic [31:0]       req_long_table_size,
   input  logic [31:0]       req_boot_root_cluster,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_is_fat32,
   output logic [31:0]       rsp_volume_sectors,
   output logic [31:0]       rsp_table_sectors,
   output logic [SPAN_W-1:0] rsp_root_dir_span,
   output logic [31:0]       rsp_first_fat_lba,
   output logic [31:0]       rsp_root_region_lba,
   output logic [31:0]       rsp_data_area_lba,
   output logic [31:0]       rsp_root_start_cluster,
   output logic [31:0]       rsp_cluster_total
);

   logic                  advance;
   logic                  front_valid;
   logic [SPAN_NUM_W-1:0] front_num;
   logic [SPAN_DEN_W-1:0] front_den;
   front_type             front_side;
   logic                  span_valid;
   logic [SPAN_NUM_W-1:0] span_quo;
   front_type             span_side;
   logic                  mid_valid;
   logic [CLUS_NUM_W-1:0] mid_num;
   logic [CLUS_DEN_W-1:0] mid_den;
   mid_type               mid_side;
   logic                  clus_valid;
   logic [CLUS_NUM_W-1:0] clus_quo;
   mid_type               clus_side;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   fvg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (req_valid),
      .partition_start   (req_partition_start),
      .sector_bytes      (req_sector_bytes),
      .cluster_sectors   (req_cluster_sectors),
      .reserved_count    (req_reserved_count),
      .table_copies      (req_table_copies),
      .root_entry_count  (req_root_entry_count),
      .short_total       (req_short_total),
      .long_total        (req_long_total),
      .short_table_size  (req_short_table_size),
      .long_table_size   (req_long_table_size),
      .boot_root_cluster (req_boot_root_cluster),
      .out_valid         (front_valid),
      .out_num           (front_num),
      .out_den           (front_den),
      .out_side          (front_side)
   );

   fvg_div_pipe #(
      .NUM_W  (SPAN_NUM_W),
      .DEN_W  (SPAN_DEN_W),
      .SIDE_W ($bits(front_type))
   ) u_span_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (span_valid),
      .out_quo   (span_quo),
      .out_side  (span_side)
   );

   fvg_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (span_valid),
      .in_quo    (span_quo),
      .in_side   (span_side),
      .out_valid (mid_valid),
      .out_num   (mid_num),
      .out_den   (mid_den),
      .out_side  (mid_side)
   );

   fvg_div_pipe #(
      .NUM_W  (CLUS_NUM_W),
      .DEN_W  (CLUS_DEN_W),
      .SIDE_W ($bits(mid_type))
   ) u_clus_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mid_valid),
      .in_num    (mid_num),
      .in_den    (mid_den),
      .in_side   (mid_side),
      .out_valid (clus_valid),
      .out_quo   (clus_quo),
      .out_side  (clus_side)
   );

   fvg_back u_back (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .in_valid           (clus_valid),
      .in_quo             (clus_quo),
      .in_side            (clus_side),
      .out_valid          (rsp_valid),
      .status             (rsp_status),
      .is_fat32           (rsp_is_fat32),
      .volume_sectors     (rsp_volume_sectors),
      .table_sectors      (rsp_table_sectors),
      .root_dir_span      (rsp_root_dir_span),
      .first_fat_lba      (rsp_first_fat_lba),
      .root_region_lba    (rsp_root_region_lba),
      .data_area_lba      (rsp_data_area_lba),
      .root_start_cluster (rsp_root_start_cluster),
      .cluster_total      (rsp_cluster_total)
   );

   `FVG_ASSERT_NOW(a_error_zeroed, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_volume_sectors == '0) && (rsp_cluster_total == '0) && !rsp_is_fat32,
      "error response carries nonzero fields")
   `FVG_ASSERT_NOW(a_ok_not_fat12, rsp_valid && (rsp_status == STATUS_OK),
      rsp_cluster_total >= 32'(LIMIT_FAT12), "good response below the FAT16 cluster minimum")
   `FVG_ASSERT_NOW(a_fat32_count, rsp_valid && rsp_is_fat32,
      rsp_cluster_total >= 32'(LIMIT_FAT16), "FAT32 response below the FAT32 cluster minimum")
   `FVG_ASSERT_NEXT(a_stall_holds_count, rsp_valid && rsp_stall,
      $stable(rsp_cluster_total) && $stable(rsp_data_area_lba),
      "stalled pipeline changed the response")

endmodule
